### rtl/core/npcm_pkg.sv
// ----------------------------------------------------------------------------
// npcm_pkg
// Shared constants and types for the nearest palette color match core.
// ----------------------------------------------------------------------------
`default_nettype none

package npcm_pkg;

  localparam int unsigned DefaultDepth = 64;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned ColorW = 3 * ChanW;
  localparam int unsigned CountW = 7;
  localparam int unsigned IndexW = 6;
  localparam int unsigned WeightW = 7;
  localparam int unsigned ProdW  = 14;
  localparam int unsigned SqW    = 2 * ProdW;
  localparam int unsigned DistW  = 29;

  localparam logic [WeightW-1:0] WeightR = 7'd30;
  localparam logic [WeightW-1:0] WeightG = 7'd59;
  localparam logic [WeightW-1:0] WeightB = 7'd11;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRun   = 4'b0010,
    StDrain = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

### rtl/core/npcm_palette_ram.sv
// ----------------------------------------------------------------------------
// npcm_palette_ram
// Single-port-write, single-port-read palette memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_palette_ram #(
  parameter int unsigned Depth = npcm_pkg::DefaultDepth,
  parameter int unsigned AddrW = 6
) (
  input  wire                    clk_i,
  input  wire                    we_i,
  input  wire  [AddrW-1:0]       waddr_i,
  input  npcm_pkg::color_t       wdata_i,
  input  wire                    re_i,
  input  wire  [AddrW-1:0]       raddr_i,
  output npcm_pkg::color_t       rdata_o
);

  npcm_pkg::color_t mem [Depth];
  npcm_pkg::color_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/npcm_dist.sv
// ----------------------------------------------------------------------------
// npcm_dist
// Three-stage weighted squared distance pipeline: weighted difference,
// square, sum.
// ----------------------------------------------------------------------------
`default_nettype none

module npcm_dist #(
  parameter int unsigned IdxW = 6
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          vld_i,
  input  wire  [IdxW-1:0]              idx_i,
  input  npcm_pkg::color_t             query_i,
  input  npcm_pkg::color_t             entry_i,
  output logic                         busy_o,
  output logic                         vld_o,
  output logic [IdxW-1:0]              idx_o,
  output logic [npcm_pkg::DistW-1:0]   dist_o
);

  logic [2:0]                    vld_q;
  logic [IdxW-1:0]               idx1_q, idx2_q, idx3_q;
  logic [npcm_pkg::ProdW-1:0]    pr_q, pg_q, pb_q;
  logic [npcm_pkg::SqW-1:0]      sr_q, sg_q, sb_q;
  logic [npcm_pkg::DistW-1:0]    sum_q;
  logic [npcm_pkg::ChanW-1:0]    dr, dg, db;

  always_comb begin
    dr = (query_i.red > entry_i.red) ? query_i.red - entry_i.red
                                     : entry_i.red - query_i.red;
    dg = (query_i.green > entry_i.green) ? query_i.green - entry_i.green
                                         : entry_i.green - query_i.green;
    db = (query_i.blue > entry_i.blue) ? query_i.blue - entry_i.blue
                                       : entry_i.blue - query_i.blue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q   <= npcm_pkg::ProdW'(dr * npcm_pkg::WeightR);
    pg_q   <= npcm_pkg::ProdW'(dg * npcm_pkg::WeightG);
    pb_q   <= npcm_pkg::ProdW'(db * npcm_pkg::WeightB);
    idx1_q <= idx_i;
    sr_q   <= npcm_pkg::SqW'(pr_q * pr_q);
    sg_q   <= npcm_pkg::SqW'(pg_q * pg_q);
    sb_q   <= npcm_pkg::SqW'(pb_q * pb_q);
    idx2_q <= idx1_q;
    sum_q  <= npcm_pkg::DistW'(sr_q) + npcm_pkg::DistW'(sg_q)
            + npcm_pkg::DistW'(sb_q);
    idx3_q <= idx2_q;
  end

  assign busy_o = |vld_q;
  assign vld_o  = vld_q[2];
  assign idx_o  = idx3_q;
  assign dist_o = sum_q;

endmodule

`default_nettype wire

### rtl/core/nearest_palette_color_match_core.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_match_core
// Palette store with a weighted nearest-color search.
// ----------------------------------------------------------------------------
// A load word writes one RGB entry into the palette memory. A query word
// scans entries 0 to N-1 (N = entries_in_use, capped at PALETTE_DEPTH),
// one memory read per cycle, through a three-stage distance pipeline, and
// returns the first entry with the least weighted distance
// (30dR)^2+(59dG)^2+(11dB)^2. found is 0 with zero index and distance
// when N is 0. The palette is undefined after reset: load every searched
// entry before querying.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_match_core #(
  parameter int unsigned PALETTE_DEPTH = npcm_pkg::DefaultDepth
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [npcm_pkg::CountW-1:0]      cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              command_i,
  input  wire  [npcm_pkg::IndexW-1:0]      entry_index_i,
  input  wire  [npcm_pkg::ChanW-1:0]       red_i,
  input  wire  [npcm_pkg::ChanW-1:0]       green_i,
  input  wire  [npcm_pkg::ChanW-1:0]       blue_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [npcm_pkg::IndexW-1:0]      best_index_o,
  output logic [npcm_pkg::DistW-1:0]       best_distance_o,
  output logic                             found_o
);

  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(PALETTE_DEPTH + 1);

  npcm_pkg::state_e               state_q, state_d;
  logic [npcm_pkg::CountW-1:0]    entries_in_use_q;
  logic [CntW-1:0]                count_q, count_d;
  logic [CntW-1:0]                addr_q, addr_d;
  logic                           rd_vld_q;
  logic [AddrW-1:0]               rd_idx_q;
  npcm_pkg::color_t               query_q;
  npcm_pkg::color_t               in_color;
  npcm_pkg::color_t               rdata;
  logic                           have_q;
  logic [AddrW-1:0]               best_i_q;
  logic [npcm_pkg::DistW-1:0]     best_d_q;
  logic                           out_valid_q;
  logic [npcm_pkg::IndexW-1:0]    out_index_q;
  logic [npcm_pkg::DistW-1:0]     out_dist_q;
  logic                           out_found_q;
  logic                           in_acc;
  logic                           issue;
  logic                           ram_we;
  logic                           dist_busy;
  logic                           dist_vld;
  logic [AddrW-1:0]               dist_idx;
  logic [npcm_pkg::DistW-1:0]     dist_val;
  logic                           finish;

  assign in_color = '{red: red_i, green: green_i, blue: blue_i};
  assign in_ready_o = (state_q == npcm_pkg::StIdle);
  assign in_acc = in_valid_i && in_ready_o;
  assign ram_we = in_acc && (command_i == npcm_pkg::CmdLoad)
               && (32'(entry_index_i) < PALETTE_DEPTH);
  assign issue = (state_q == npcm_pkg::StRun);
  assign finish = (state_q == npcm_pkg::StDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (32'(entries_in_use_q) > PALETTE_DEPTH) begin
      count_d = CntW'(PALETTE_DEPTH);
    end else begin
      count_d = CntW'(entries_in_use_q);
    end
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    case (state_q)
      npcm_pkg::StIdle: begin
        addr_d = '0;
        if (in_acc && (command_i == npcm_pkg::CmdQuery)) begin
          state_d = (count_d == '0) ? npcm_pkg::StDone : npcm_pkg::StRun;
        end
      end
      npcm_pkg::StRun: begin
        addr_d = addr_q + CntW'(1);
        if (addr_q == count_q - CntW'(1)) begin
          state_d = npcm_pkg::StDrain;
        end
      end
      npcm_pkg::StDrain: begin
        if (!rd_vld_q && !dist_busy) begin
          state_d = npcm_pkg::StDone;
        end
      end
      npcm_pkg::StDone: begin
        if (finish) begin
          state_d = npcm_pkg::StIdle;
        end
      end
      default: begin
        state_d = npcm_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= npcm_pkg::StIdle;
      entries_in_use_q <= '0;
      rd_vld_q         <= 1'b0;
      have_q           <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_we_i) begin
        entries_in_use_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        have_q <= 1'b0;
      end else if (dist_vld && (!have_q || dist_val < best_d_q)) begin
        have_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    rd_idx_q <= addr_q[AddrW-1:0];
    if (in_acc) begin
      query_q  <= in_color;
      count_q  <= count_d;
      best_i_q <= '0;
      best_d_q <= '0;
    end else if (dist_vld && (!have_q || dist_val < best_d_q)) begin
      best_i_q <= dist_idx;
      best_d_q <= dist_val;
    end
    if (finish) begin
      out_index_q <= npcm_pkg::IndexW'(best_i_q);
      out_dist_q  <= best_d_q;
      out_found_q <= have_q;
    end
  end

  npcm_palette_ram #(
    .Depth (PALETTE_DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(entry_index_i)),
    .wdata_i (in_color),
    .re_i    (issue),
    .raddr_i (addr_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  npcm_dist #(
    .IdxW (AddrW)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (rd_vld_q),
    .idx_i   (rd_idx_q),
    .query_i (query_q),
    .entry_i (rdata),
    .busy_o  (dist_busy),
    .vld_o   (dist_vld),
    .idx_o   (dist_idx),
    .dist_o  (dist_val)
  );

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = out_index_q;
  assign best_distance_o = out_dist_q;
  assign found_o         = out_found_q;

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearest palette color match core.
// ----------------------------------------------------------------------------
// Palette loads and color queries go in over a valid/ready channel; a
// scoreboard keeps its own palette copy and search count, computes the
// weighted nearest entry for every accepted query and compares each
// returned word field by field. A short directed run covers the empty
// search, the largest distance, exact matches and ties. Random phases
// follow. Each one sets a new search count, below, at and above the depth,
// and fills any slot it needs first. Sender and receiver stall at random
// in two idling modes, then both run without stalls.
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import npcm_pkg::*;

  localparam int unsigned Depth        = DefaultDepth;
  localparam int unsigned RandomWords  = 1800;
  localparam int unsigned QuietCycles  = Depth + 16;
  localparam int unsigned WatchdogMax  = 4000;

  typedef struct packed {
    logic [IndexW-1:0] best_index;
    logic [DistW-1:0]  best_distance;
    logic              found;
  } match_t;

  class palette_scoreboard;
    color_t      palette[Depth];
    int unsigned search_count;
    match_t      match_q[$];
    int unsigned failures;

    function void set_count(logic [CountW-1:0] value);
      search_count = (value > Depth) ? Depth : value;
    endfunction

    function int unsigned channel_term(logic [ChanW-1:0] a, logic [ChanW-1:0] b,
                                       int unsigned weight);
      int unsigned diff;
      diff = (a > b) ? a - b : b - a;
      return (diff * weight) * (diff * weight);
    endfunction

    function void note_word(logic cmd, logic [IndexW-1:0] idx, color_t color);
      match_t      best;
      int unsigned distance;
      if (cmd == CmdLoad) begin
        if (idx < Depth) palette[idx] = color;
        return;
      end
      best = '0;
      for (int unsigned i = 0; i < search_count; i++) begin
        distance = channel_term(color.red, palette[i].red, WeightR)
                 + channel_term(color.green, palette[i].green, WeightG)
                 + channel_term(color.blue, palette[i].blue, WeightB);
        if (!best.found || distance < best.best_distance) begin
          best.best_index    = i[IndexW-1:0];
          best.best_distance = distance[DistW-1:0];
          best.found         = 1'b1;
        end
      end
      match_q.push_back(best);
    endfunction

    function void check_result(match_t got);
      match_t want;
      if (match_q.size() == 0) begin
        $error("result word with none expected: index %0d distance %0d found %0d",
               got.best_index, got.best_distance, got.found);
        failures++;
        return;
      end
      want = match_q.pop_front();
      if (got.best_index !== want.best_index) begin
        $error("best_index: expected %0d, got %0d", want.best_index, got.best_index);
        failures++;
      end
      if (got.best_distance !== want.best_distance) begin
        $error("best_distance: expected %0d, got %0d",
               want.best_distance, got.best_distance);
        failures++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return match_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [CountW-1:0]   cfg_wdata   = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  logic                command     = CmdLoad;
  logic [IndexW-1:0]   entry_index = '0;
  logic [ChanW-1:0]    red         = '0;
  logic [ChanW-1:0]    green       = '0;
  logic [ChanW-1:0]    blue        = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [IndexW-1:0]   best_index;
  logic [DistW-1:0]    best_distance;
  logic                found;

  palette_scoreboard   sb;
  bit                  loaded[Depth];
  int unsigned         tx_idle_pct = 24;
  int unsigned         rx_idle_pct = 81;
  int unsigned         words_sent  = 0;
  int unsigned         quiet_cycles = 0;

  nearest_palette_color_match_core #(
    .PALETTE_DEPTH(Depth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .command_i      (command),
    .entry_index_i  (entry_index),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .best_index_o   (best_index),
    .best_distance_o(best_distance),
    .found_o        (found)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{best_index, best_distance, found});
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogMax) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic cmd, input logic [IndexW-1:0] idx,
                           input color_t color);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    red         <= color.red;
    green       <= color.green;
    blue        <= color.blue;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_word(cmd, idx, color);
    if (cmd == CmdLoad) loaded[idx] = 1'b1;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (QuietCycles) @(negedge clk_i);
  endtask

  task automatic write_count(input int unsigned value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[CountW-1:0];
    @(posedge clk_i);
    sb.set_count(value[CountW-1:0]);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ChanW-1:0] nudge(logic [ChanW-1:0] chan);
    int value;
    value = int'(chan) + int'($urandom_range(8)) - 4;
    if (value < 0) value = 0;
    if (value > 255) value = 255;
    return value[ChanW-1:0];
  endfunction

  function automatic color_t corner_color();
    color_t color;
    color.red   = $urandom_range(1) ? 8'hFF : 8'h00;
    color.green = $urandom_range(1) ? 8'hFF : 8'h00;
    color.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    return color;
  endfunction

  function automatic color_t query_color();
    color_t color;
    color = ColorW'($urandom());
    if (sb.search_count > 0) begin
      case ($urandom_range(9))
        4, 5, 6: color = sb.palette[$urandom_range(sb.search_count - 1)];
        7, 8: begin
          color = sb.palette[$urandom_range(sb.search_count - 1)];
          color = '{nudge(color.red), nudge(color.green), nudge(color.blue)};
        end
        9:       color = corner_color();
        default: ;
      endcase
    end
    return color;
  endfunction

  function automatic color_t load_color();
    color_t color;
    color = ColorW'($urandom());
    case ($urandom_range(9))
      6, 7: if (sb.search_count > 0) color = sb.palette[$urandom_range(sb.search_count - 1)];
      8, 9:    color = corner_color();
      default: ;
    endcase
    return color;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned count;
    int unsigned burst;
    sb = new;
    repeat (10) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    write_count(0);
    send_word(CmdQuery, 6'd0, '{8'hFF, 8'hFF, 8'hFF});
    send_word(CmdLoad, 6'd0, '{8'h00, 8'h00, 8'h00});
    send_word(CmdLoad, 6'd1, '{8'hFF, 8'hFF, 8'hFF});
    send_word(CmdLoad, 6'd2, '{8'h00, 8'h00, 8'h00});
    send_word(CmdLoad, 6'd63, '{8'hFF, 8'h00, 8'hFF});
    write_count(1);
    send_word(CmdQuery, 6'd63, '{8'hFF, 8'hFF, 8'hFF});
    send_word(CmdQuery, 6'd0, '{8'h00, 8'h00, 8'h00});
    write_count(3);
    send_word(CmdQuery, 6'd0, '{8'h00, 8'h00, 8'h00});
    send_word(CmdQuery, 6'd0, '{8'hFF, 8'hFF, 8'hFF});
    send_word(CmdQuery, 6'd0, '{8'h80, 8'h80, 8'h80});
    send_word(CmdQuery, 6'd0, '{8'hFF, 8'h00, 8'h00});
    send_word(CmdQuery, 6'd0, '{8'h00, 8'hFF, 8'h00});
    send_word(CmdQuery, 6'd0, '{8'h00, 8'h00, 8'hFF});

    phase = 0;
    while (words_sent < RandomWords) begin
      if (words_sent < RandomWords / 3) begin
        tx_idle_pct = 24;
        rx_idle_pct = 81;
      end else if (words_sent < 2 * RandomWords / 3) begin
        tx_idle_pct = 81;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == 0) begin
        count = 127;
      end else if (phase == 1) begin
        count = Depth;
      end else begin
        case ($urandom_range(9))
          0:       count = 0;
          1:       count = 1;
          2:       count = Depth;
          3:       count = $urandom_range(Depth + 1, 127);
          default: count = $urandom_range(2, Depth - 1);
        endcase
      end
      write_count(count);
      for (int unsigned i = 0; i < sb.search_count; i++) begin
        if (!loaded[i]) begin
          send_word(CmdLoad, i[IndexW-1:0], load_color());
          words_sent++;
        end
      end
      burst = $urandom_range(15, 50);
      repeat (burst) begin
        if ($urandom_range(3) == 0) begin
          send_word(CmdLoad, IndexW'($urandom_range(Depth - 1)), load_color());
        end else begin
          send_word(CmdQuery, IndexW'($urandom_range(Depth - 1)), query_color());
        end
        words_sent++;
      end
      phase++;
    end

    wait_drained();
    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### nearest_palette_color_match_core.f
rtl/core/npcm_pkg.sv
rtl/core/npcm_palette_ram.sv
rtl/core/npcm_dist.sv
rtl/core/nearest_palette_color_match_core.sv
verif/tb_top.sv
